// ===== design/brop_pkg.sv =====
// Shared types, command bit positions and helpers for the blitter raster-op datapath.
package brop_pkg;

	// Command register bit positions
	localparam int unsigned CmdZWrite    = 5;
	localparam int unsigned CmdClip      = 6;
	localparam int unsigned CmdNoSatLo   = 14;
	localparam int unsigned CmdNoSatMid  = 15;
	localparam int unsigned CmdPattern   = 16;
	localparam int unsigned CmdAdd       = 17;
	localparam int unsigned CmdZLt       = 18;
	localparam int unsigned CmdZEq       = 19;
	localparam int unsigned CmdZGt       = 20;
	localparam int unsigned CmdLfu0      = 21;
	localparam int unsigned CmdLfu1      = 22;
	localparam int unsigned CmdLfu2      = 23;
	localparam int unsigned CmdLfu3      = 24;
	localparam int unsigned CmdDcmpDst   = 25;
	localparam int unsigned CmdDcmp      = 27;
	localparam int unsigned CmdForce     = 28;
	localparam int unsigned CmdShade     = 30;

	// Configuration register indexes
	localparam logic [2:0] RegCommand    = 3'd0;
	localparam logic [2:0] RegClipWidth  = 3'd1;
	localparam logic [2:0] RegClipHeight = 3'd2;
	localparam logic [2:0] RegShadeDelta = 3'd3;
	localparam logic [2:0] RegDepthCode  = 3'd4;
	localparam logic [2:0] RegPhraseMode = 3'd5;

	// Pixel size codes
	localparam logic [2:0] Depth1  = 3'd0;
	localparam logic [2:0] Depth2  = 3'd1;
	localparam logic [2:0] Depth4  = 3'd2;
	localparam logic [2:0] Depth8  = 3'd3;
	localparam logic [2:0] Depth16 = 3'd4;
	localparam logic [2:0] Depth32 = 3'd5;

	typedef struct packed {
		logic [31:0]       command;
		logic [14:0]       clip_width;
		logic [14:0]       clip_height;
		logic signed [7:0] shade_delta;
		logic [2:0]        depth_code;
		logic              phrase_mode;
	} cfg_t;

	// Stage 1 word: inhibit decided, partial data results
	typedef struct packed {
		logic              inhibit;
		logic [7:0]        src_hi;
		logic [31:0]       dst;
		logic [31:0]       pat_d;
		logic [31:0]       lfu;
		logic [8:0]        add_lo;
		logic [4:0]        add_mid;
		logic [4:0]        add_hi;
		logic signed [9:0] shade_sum;
		logic [31:0]       depth;
	} s1_t;

	// Stage 2 word: unmasked write data
	typedef struct packed {
		logic        inhibit;
		logic [31:0] wdata;
		logic [31:0] depth;
	} s2_t;

	function automatic logic [31:0] depth_mask(input logic [2:0] code);
		logic [31:0] m;
		unique case (code)
			Depth1:  m = 32'h0000_0001;
			Depth2:  m = 32'h0000_0003;
			Depth4:  m = 32'h0000_000f;
			Depth8:  m = 32'h0000_00ff;
			Depth16: m = 32'h0000_ffff;
			Depth32: m = 32'hffff_ffff;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

endpackage

// ===== design/brop_cfg_regs.sv =====
// Configuration register file of the blitter raster-op datapath.
module brop_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output brop_pkg::cfg_t   cfg
);

	brop_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				brop_pkg::RegCommand:    cfg_q.command     <= cfg_data;
				brop_pkg::RegClipWidth:  cfg_q.clip_width  <= cfg_data[14:0];
				brop_pkg::RegClipHeight: cfg_q.clip_height <= cfg_data[14:0];
				brop_pkg::RegShadeDelta: cfg_q.shade_delta <= cfg_data[7:0];
				brop_pkg::RegDepthCode:  cfg_q.depth_code  <= cfg_data[2:0];
				brop_pkg::RegPhraseMode: cfg_q.phrase_mode <= cfg_data[0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/brop_stage1.sv =====
// Stage 1: inhibit tests and partial sums of the write data.
module brop_stage1 (
	input  logic             clk,
	input  logic             load,
	input  brop_pkg::cfg_t   cfg,
	input  logic [31:0]      src_pixel,
	input  logic [31:0]      dst_pixel,
	input  logic [31:0]      src_depth,
	input  logic [31:0]      dst_depth,
	input  logic signed [15:0] dest_x,
	input  logic signed [15:0] dest_y,
	input  logic [31:0]      pattern_at_src,
	input  logic [31:0]      pattern_at_dst,
	output brop_pkg::s1_t    s1
);

	brop_pkg::s1_t nxt;
	brop_pkg::s1_t word_s1;
	logic          clip_hit;
	logic          z_hit;
	logic          dcmp_hit;
	logic [31:0]   cmd;

	always_comb begin
		cmd = cfg.command;
		clip_hit = cmd[brop_pkg::CmdClip] &&
			(dest_x[15] || dest_y[15] ||
			 (dest_x[14:0] >= cfg.clip_width) || (dest_y[14:0] >= cfg.clip_height));
		z_hit = (cmd[brop_pkg::CmdZLt] && (src_depth <  dst_depth)) ||
			(cmd[brop_pkg::CmdZEq] && (src_depth == dst_depth)) ||
			(cmd[brop_pkg::CmdZGt] && (src_depth >  dst_depth));
		if (cmd[brop_pkg::CmdDcmpDst])
			dcmp_hit = cmd[brop_pkg::CmdDcmp] && (dst_pixel == pattern_at_dst);
		else
			dcmp_hit = cmd[brop_pkg::CmdDcmp] && (src_pixel == pattern_at_src);

		nxt.inhibit = clip_hit || z_hit || dcmp_hit;
		nxt.src_hi  = src_pixel[15:8];
		nxt.dst     = dst_pixel;
		nxt.pat_d   = pattern_at_dst;
		nxt.lfu     = ({32{cmd[brop_pkg::CmdLfu0]}} & ~src_pixel & ~dst_pixel) |
			({32{cmd[brop_pkg::CmdLfu1]}} & ~src_pixel &  dst_pixel) |
			({32{cmd[brop_pkg::CmdLfu2]}} &  src_pixel & ~dst_pixel) |
			({32{cmd[brop_pkg::CmdLfu3]}} &  src_pixel &  dst_pixel);
		nxt.add_lo  = {1'b0, src_pixel[7:0]} + {1'b0, dst_pixel[7:0]};
		nxt.add_mid = {1'b0, src_pixel[11:8]} + {1'b0, dst_pixel[11:8]};
		nxt.add_hi  = {1'b0, src_pixel[15:12]} + {1'b0, dst_pixel[15:12]};
		nxt.shade_sum = $signed({2'b00, src_pixel[7:0]}) +
			$signed({{2{cfg.shade_delta[7]}}, cfg.shade_delta});
		nxt.depth   = src_depth;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s1 <= nxt;
		end
	end

	assign s1 = word_s1;

endmodule

// ===== design/brop_stage2.sv =====
// Stage 2: saturation, intensity clamp and write data select.
module brop_stage2 (
	input  logic             clk,
	input  logic             load,
	input  brop_pkg::cfg_t   cfg,
	input  brop_pkg::s1_t    s1,
	output brop_pkg::s2_t    s2
);

	brop_pkg::s2_t nxt;
	brop_pkg::s2_t word_s2;
	logic [8:0]    lo_sat;
	logic [12:0]   mid_or;
	logic [12:0]   mid_sat;
	logic [16:0]   add_res;
	logic [7:0]    inten;
	logic [31:0]   base;
	logic [31:0]   cmd;

	always_comb begin
		cmd = cfg.command;
		// without saturation, a carry out of a component stays and ORs into the next one
		lo_sat  = (!cmd[brop_pkg::CmdNoSatLo] && s1.add_lo[8]) ? 9'h0ff : s1.add_lo;
		mid_or  = {s1.add_mid, 8'h00} | {4'h0, lo_sat};
		mid_sat = (!cmd[brop_pkg::CmdNoSatMid] && mid_or[12]) ? 13'h0fff : mid_or;
		add_res = {s1.add_hi, 12'h000} | {4'h0, mid_sat};

		if (s1.shade_sum[9])
			inten = 8'h00;
		else if (s1.shade_sum[8])
			inten = 8'hff;
		else
			inten = s1.shade_sum[7:0];

		if (cmd[brop_pkg::CmdPattern])
			base = s1.pat_d;
		else if (cmd[brop_pkg::CmdAdd])
			base = {15'h0000, add_res};
		else
			base = s1.lfu;

		nxt.inhibit = s1.inhibit;
		nxt.depth   = s1.depth;
		if (s1.inhibit)
			nxt.wdata = s1.dst;
		else if (cmd[brop_pkg::CmdShade])
			nxt.wdata = {16'h0000, s1.src_hi, inten};
		else
			nxt.wdata = base;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_s2 <= nxt;
		end
	end

	assign s2 = word_s2;

endmodule

// ===== design/brop_stage3.sv =====
// Stage 3: write enables and depth masking into the output register.
module brop_stage3 (
	input  logic             clk,
	input  logic             load,
	input  brop_pkg::cfg_t   cfg,
	input  brop_pkg::s2_t    s2,
	output logic             pixel_write,
	output logic [31:0]      pixel_value,
	output logic             depth_write,
	output logic [31:0]      depth_value
);

	logic        wr;
	logic        pwr_s3;
	logic [31:0] pval_s3;
	logic        dwr_s3;
	logic [31:0] dval_s3;

	always_comb begin
		wr = (cfg.phrase_mode || cfg.command[brop_pkg::CmdForce] || !s2.inhibit) &&
			(cfg.depth_code <= brop_pkg::Depth32);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pwr_s3  <= wr;
			pval_s3 <= wr ? (s2.wdata & brop_pkg::depth_mask(cfg.depth_code)) : 32'h0;
			dwr_s3  <= wr && cfg.command[brop_pkg::CmdZWrite];
			dval_s3 <= s2.depth;
		end
	end

	assign pixel_write = pwr_s3;
	assign pixel_value = pval_s3;
	assign depth_write = dwr_s3;
	assign depth_value = dval_s3;

endmodule

// ===== design/blitter_pixel_raster_op.sv =====
// Top level of the blitter per-pixel raster-op datapath.
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   src/dst pixel and Z, dest x/y, pattern lanes
//  result   out        out_valid/out_stall pixel_write/value, depth_write/value
//  config   in         cfg_write_en        cfg_index, cfg_data
//
// One word enters per clock while in_stall is low; each word taken passes through the
// stage 1, 2 and 3 registers. Stage 1 holds the compares (clip, Z, pattern) and partial sums, stage 2 the
// saturation, clamp and data select, stage 3 the masking and the output register.
// Reset clears the valid bits and the configuration registers.
// A stalled output holds stage 3; a stage takes a new word whenever it is empty
// or its word moves on, so bubbles collapse and in_stall rises only when all
// three stages are full and the output is stalled.
module blitter_pixel_raster_op (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        src_pixel,
	input  logic [31:0]        dst_pixel,
	input  logic [31:0]        src_depth,
	input  logic [31:0]        dst_depth,
	input  logic signed [15:0] dest_x,
	input  logic signed [15:0] dest_y,
	input  logic [31:0]        pattern_at_src,
	input  logic [31:0]        pattern_at_dst,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               pixel_write,
	output logic [31:0]        pixel_value,
	output logic               depth_write,
	output logic [31:0]        depth_value
);

	brop_pkg::cfg_t cfg;
	brop_pkg::s1_t  s1;
	brop_pkg::s2_t  s2;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic ready1;
	logic ready2;
	logic ready3;

	// A stage can load when it is empty or its word advances this cycle.
	assign ready3   = !v_s3 || !out_stall;
	assign ready2   = !v_s2 || ready3;
	assign ready1   = !v_s1 || ready2;
	assign in_stall = !ready1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready1) v_s1 <= in_valid;
			if (ready2) v_s2 <= v_s1;
			if (ready3) v_s3 <= v_s2;
		end
	end

	brop_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Load payload only with a real word, so bubbles leave the data alone.
	brop_stage1 u_s1 (
		.clk            (clk),
		.load           (ready1 && in_valid),
		.cfg            (cfg),
		.src_pixel      (src_pixel),
		.dst_pixel      (dst_pixel),
		.src_depth      (src_depth),
		.dst_depth      (dst_depth),
		.dest_x         (dest_x),
		.dest_y         (dest_y),
		.pattern_at_src (pattern_at_src),
		.pattern_at_dst (pattern_at_dst),
		.s1             (s1)
	);

	brop_stage2 u_s2 (
		.clk  (clk),
		.load (ready2 && v_s1),
		.cfg  (cfg),
		.s1   (s1),
		.s2   (s2)
	);

	brop_stage3 u_s3 (
		.clk         (clk),
		.load        (ready3 && v_s2),
		.cfg         (cfg),
		.s2          (s2),
		.pixel_write (pixel_write),
		.pixel_value (pixel_value),
		.depth_write (depth_write),
		.depth_value (depth_value)
	);

	// Z is only written along with the pixel.
	a_zwrite_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_write |-> pixel_write)
		else $error("depth_write without pixel_write");

	// A word that writes nothing carries zero data.
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pixel_write |-> pixel_value == 32'h0)
		else $error("pixel_value not zero on a non-write");

	// Back-pressure reaches the input only with every stage full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && out_stall)
		else $error("input stalled with room in the pipeline");

	// A word held at a stalled output is still there next cycle.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result word lost");

endmodule

// ===== test/raster_op_checker.sv =====
// Checker for the blitter raster-op datapath: predicts every write word and compares it.
module raster_op_checker
	import brop_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [31:0]        src_pixel,
	input  logic [31:0]        dst_pixel,
	input  logic [31:0]        src_depth,
	input  logic [31:0]        dst_depth,
	input  logic signed [15:0] dest_x,
	input  logic signed [15:0] dest_y,
	input  logic [31:0]        pattern_at_src,
	input  logic [31:0]        pattern_at_dst,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               pixel_write,
	input  logic [31:0]        pixel_value,
	input  logic               depth_write,
	input  logic [31:0]        depth_value,
	output int                 pending,
	output int                 fail_count
);

	typedef struct packed {
		logic        pixel_write;
		logic [31:0] pixel_value;
		logic        depth_write;
		logic [31:0] depth_value;
	} write_word_t;

	cfg_t        regs;
	write_word_t writes_due[$];

	// Inhibit decision, data path and depth masking for one pixel under the current registers.
	function automatic write_word_t raster_op(
		input logic [31:0]        s,
		input logic [31:0]        d,
		input logic [31:0]        sz,
		input logic [31:0]        dz,
		input logic signed [15:0] x,
		input logic signed [15:0] y,
		input logic [31:0]        pat_s,
		input logic [31:0]        pat_d
	);
		write_word_t w;
		logic        inhibit;
		logic        wr;
		logic [31:0] wd;
		logic [31:0] mask;
		logic [31:0] cmd;
		int          xi, yi, cw, ch, inten;
		cmd     = regs.command;
		xi      = int'(x);
		yi      = int'(y);
		cw      = int'(regs.clip_width);
		ch      = int'(regs.clip_height);
		inhibit = 1'b0;
		wd      = '0;
		if (cmd[CmdClip] && (xi < 0 || yi < 0 || xi >= cw || yi >= ch))
			inhibit = 1'b1;
		if (cmd[CmdZLt] && sz < dz)
			inhibit = 1'b1;
		if (cmd[CmdZEq] && sz == dz)
			inhibit = 1'b1;
		if (cmd[CmdZGt] && sz > dz)
			inhibit = 1'b1;
		if (cmd[CmdDcmp]) begin
			if (cmd[CmdDcmpDst] ? (d == pat_d) : (s == pat_s))
				inhibit = 1'b1;
		end
		if (!inhibit) begin
			if (cmd[CmdPattern]) begin
				wd = pat_d;
			end else if (cmd[CmdAdd]) begin
				wd = (s & 32'h0000_00ff) + (d & 32'h0000_00ff);
				if (!cmd[CmdNoSatLo] && wd > 32'h0000_00ff)
					wd = 32'h0000_00ff;
				wd |= (s & 32'h0000_0f00) + (d & 32'h0000_0f00);
				if (!cmd[CmdNoSatMid] && wd > 32'h0000_0fff)
					wd = 32'h0000_0fff;
				wd |= (s & 32'h0000_f000) + (d & 32'h0000_f000);
			end else begin
				if (cmd[CmdLfu0])
					wd |= ~s & ~d;
				if (cmd[CmdLfu1])
					wd |= ~s & d;
				if (cmd[CmdLfu2])
					wd |= s & ~d;
				if (cmd[CmdLfu3])
					wd |= s & d;
			end
			if (cmd[CmdShade]) begin
				inten = int'(s[7:0]) + int'($signed(regs.shade_delta));
				if (inten < 0)
					inten = 0;
				else if (inten > 255)
					inten = 255;
				wd = {16'h0000, s[15:8], 8'(inten)};
			end
		end else begin
			wd = d;
		end
		wr = regs.phrase_mode || cmd[CmdForce] || !inhibit;
		if (regs.depth_code > Depth32)
			wr = 1'b0;
		if (regs.depth_code >= Depth32)
			mask = '1;
		else
			mask = (32'd1 << (32'd1 << regs.depth_code)) - 32'd1;
		w.pixel_write = wr;
		w.pixel_value = wr ? (wd & mask) : '0;
		w.depth_write = wr && cmd[CmdZWrite];
		w.depth_value = sz;
		return w;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		write_word_t want;
		if (!arst_n) begin
			regs = '0;
			writes_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					RegCommand:    regs.command     = cfg_data;
					RegClipWidth:  regs.clip_width  = cfg_data[14:0];
					RegClipHeight: regs.clip_height = cfg_data[14:0];
					RegShadeDelta: regs.shade_delta = cfg_data[7:0];
					RegDepthCode:  regs.depth_code  = cfg_data[2:0];
					RegPhraseMode: regs.phrase_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (writes_due.size() == 0) begin
					$display("%0t: result word with nothing expected, pixel_value %h",
						$time, pixel_value);
					fail_count++;
				end else begin
					want = writes_due.pop_front();
					if (pixel_write !== want.pixel_write)
						report_mismatch("pixel_write", 32'(want.pixel_write),
							32'(pixel_write));
					if (pixel_value !== want.pixel_value)
						report_mismatch("pixel_value", want.pixel_value, pixel_value);
					if (depth_write !== want.depth_write)
						report_mismatch("depth_write", 32'(want.depth_write),
							32'(depth_write));
					if (depth_value !== want.depth_value)
						report_mismatch("depth_value", want.depth_value, depth_value);
				end
			end
			if (in_valid && !in_stall)
				writes_due.push_back(raster_op(src_pixel, dst_pixel, src_depth, dst_depth,
					dest_x, dest_y, pattern_at_src, pattern_at_dst));
			pending <= writes_due.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the blitter raster-op datapath: stimulus, back-pressure and verdict.
module tb_top;
	import brop_pkg::*;

	// Random words after the directed part
	localparam int RandomItems   = 1150;
	// Cycles in which no word moves on either channel before the run is declared hung
	localparam int WatchdogLimit = 5000;
	// Slack for the tail after the pipe has drained
	localparam int DrainCycles   = 8;

	// Indexes past the last register, expected to be ignored
	localparam logic [2:0] RegUnused6 = 3'd6;
	localparam logic [2:0] RegUnused7 = 3'd7;
	// Pixel size codes with no defined size: nothing is written
	localparam logic [2:0] DepthBad6  = 3'd6;
	localparam logic [2:0] DepthBad7  = 3'd7;

	typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallBurst} stall_mode_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] sz;
		logic [31:0] dz;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] ps;
		logic [31:0] pd;
	} pixel_word_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [31:0]        src_pixel;
	logic [31:0]        dst_pixel;
	logic [31:0]        src_depth;
	logic [31:0]        dst_depth;
	logic signed [15:0] dest_x;
	logic signed [15:0] dest_y;
	logic [31:0]        pattern_at_src;
	logic [31:0]        pattern_at_dst;
	logic               out_valid;
	logic               out_stall;
	logic               pixel_write;
	logic [31:0]        pixel_value;
	logic               depth_write;
	logic [31:0]        depth_value;

	int          pending_writes;
	int          mismatches;
	int          quiet_cycles;
	int          stall_left;
	stall_mode_t stall_mode;
	// Clip limits currently programmed; coordinates are steered around them
	int          cur_clip_w;
	int          cur_clip_h;

	blitter_pixel_raster_op u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.src_pixel      (src_pixel),
		.dst_pixel      (dst_pixel),
		.src_depth      (src_depth),
		.dst_depth      (dst_depth),
		.dest_x         (dest_x),
		.dest_y         (dest_y),
		.pattern_at_src (pattern_at_src),
		.pattern_at_dst (pattern_at_dst),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_write    (pixel_write),
		.pixel_value    (pixel_value),
		.depth_write    (depth_write),
		.depth_value    (depth_value)
	);

	raster_op_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.src_pixel      (src_pixel),
		.dst_pixel      (dst_pixel),
		.src_depth      (src_depth),
		.dst_depth      (dst_depth),
		.dest_x         (dest_x),
		.dest_y         (dest_y),
		.pattern_at_src (pattern_at_src),
		.pattern_at_dst (pattern_at_dst),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_write    (pixel_write),
		.pixel_value    (pixel_value),
		.depth_write    (depth_write),
		.depth_value    (depth_value),
		.pending        (pending_writes),
		.fail_count     (mismatches)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver back-pressure: pick a new stall pattern whenever the current stretch runs out,
	// including stretches that never stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			stall_mode <= StallNone;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(20, 200);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				StallNone:  out_stall <= 1'b0;
				StallLight: out_stall <= ($urandom_range(0, 3) == 0);
				StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
				default:    out_stall <= ((stall_left % 8) < 3);
			endcase
		end
	end

	// Hang detection: count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	function automatic logic [31:0] cmd_bit(input int unsigned pos);
		return 32'd1 << pos;
	endfunction

	function automatic pixel_word_t mk(input logic [31:0] s, input logic [31:0] d,
			input logic [31:0] sz, input logic [31:0] dz, input logic [15:0] x,
			input logic [15:0] y, input logic [31:0] ps, input logic [31:0] pd);
		pixel_word_t p;
		p = '{src: s, dst: d, sz: sz, dz: dz, x: x, y: y, ps: ps, pd: pd};
		return p;
	endfunction

	// Pixel data biased toward the corners of the additive and shading math
	function automatic logic [31:0] pick_pixel();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			2:       return $urandom_range(0, 255);
			3:       return $urandom() | 32'h0000_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Coordinates mostly inside the clip limit, some on and past its edges
	function automatic logic [15:0] pick_coord(input int lim);
		case ($urandom_range(0, 7))
			0:       return 16'($urandom());
			1:       return 16'(lim + int'($urandom_range(0, 2)) - 1);
			2:       return 16'(-int'($urandom_range(1, 4)));
			3:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return (lim > 0) ? 16'($urandom_range(0, lim - 1)) : 16'h0000;
		endcase
	endfunction

	// Random pixel word: Z pairs and pattern lanes often hit the compare cases
	function automatic pixel_word_t random_pixel();
		pixel_word_t p;
		p.src = pick_pixel();
		p.dst = pick_pixel();
		p.sz  = $urandom();
		case ($urandom_range(0, 3))
			0:       p.dz = p.sz;
			1:       p.dz = p.sz + 32'd1;
			2:       p.dz = p.sz - 32'd1;
			default: p.dz = $urandom();
		endcase
		p.x  = pick_coord(cur_clip_w);
		p.y  = pick_coord(cur_clip_h);
		p.ps = ($urandom_range(0, 3) == 0) ? p.src : $urandom();
		p.pd = ($urandom_range(0, 3) == 0) ? p.dst : $urandom();
		return p;
	endfunction

	// Random command word with the mode bits thinned out so that most pixels get written
	function automatic logic [31:0] random_command();
		logic [31:0] c;
		c = $urandom();
		if ($urandom_range(0, 1))
			c[CmdClip] = 1'b0;
		c[CmdZLt]    = ($urandom_range(0, 3) == 0);
		c[CmdZEq]    = ($urandom_range(0, 3) == 0);
		c[CmdZGt]    = ($urandom_range(0, 3) == 0);
		c[CmdDcmp]   = ($urandom_range(0, 3) == 0);
		c[CmdPattern] = ($urandom_range(0, 3) == 0);
		c[CmdAdd]    = ($urandom_range(0, 2) == 0);
		c[CmdShade]  = ($urandom_range(0, 3) == 0);
		c[CmdForce]  = ($urandom_range(0, 3) == 0);
		return c;
	endfunction

	function automatic logic [14:0] random_clip();
		case ($urandom_range(0, 4))
			0:       return 15'h0000;
			1:       return 15'h7fff;
			2:       return 15'($urandom_range(1, 16));
			3:       return 15'($urandom_range(1, 200));
			default: return 15'($urandom());
		endcase
	endfunction

	// Present one word and hold it until it is taken; valid stays high afterwards
	task automatic send_word(input pixel_word_t p);
		in_valid       <= 1'b1;
		src_pixel      <= p.src;
		dst_pixel      <= p.dst;
		src_depth      <= p.sz;
		dst_depth      <= p.dz;
		dest_x         <= p.x;
		dest_y         <= p.y;
		pattern_at_src <= p.ps;
		pattern_at_dst <= p.pd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted write word has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= val;
	endtask

	// Reprogram every register with junk in the unused upper bits, then poke an
	// out-of-range index that must leave them untouched.
	task automatic set_regs(input logic [31:0] cmd, input logic [14:0] cw,
			input logic [14:0] ch, input logic [7:0] delta, input logic [2:0] code,
			input logic phrase);
		wait_idle();
		cfg_write(RegCommand, cmd);
		cfg_write(RegClipWidth, ($urandom() & ~32'h7fff) | 32'(cw));
		cfg_write(RegClipHeight, ($urandom() & ~32'h7fff) | 32'(ch));
		cfg_write(RegShadeDelta, ($urandom() & ~32'hff) | 32'(delta));
		cfg_write(RegDepthCode, ($urandom() & ~32'h7) | 32'(code));
		cfg_write(RegPhraseMode, ($urandom() & ~32'h1) | 32'(phrase));
		cfg_write($urandom_range(0, 1) ? RegUnused6 : RegUnused7, $urandom());
		@(posedge clk);
		cfg_write_en <= 1'b0;
		cur_clip_w = int'(cw);
		cur_clip_h = int'(ch);
	endtask

	initial begin : stimulus
		int          sent;
		int          words;
		int          burst_left;
		int          phase;
		bit          gappy;
		logic [2:0]  code;
		arst_n         <= 1'b0;
		cfg_write_en   <= 1'b0;
		cfg_index      <= RegCommand;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		src_pixel      <= '0;
		dst_pixel      <= '0;
		src_depth      <= '0;
		dst_depth      <= '0;
		dest_x         <= '0;
		dest_y         <= '0;
		pattern_at_src <= '0;
		pattern_at_dst <= '0;
		cur_clip_w     = 0;
		cur_clip_h     = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: command zero writes zero at one bit per pixel
		send_word(mk('0, '0, '0, '0, 16'h0000, 16'h0000, '0, '0));
		send_word(mk('1, '1, '1, '1, 16'hffff, 16'hffff, '1, '1));

		// Copy source, full depth, Z write, coordinate extremes
		set_regs(cmd_bit(CmdLfu2) | cmd_bit(CmdLfu3) | cmd_bit(CmdZWrite),
			15'h7fff, 15'h7fff, 8'h00, Depth32, 1'b0);
		send_word(mk(32'hffff_ffff, 32'h0, 32'h1234_5678, 32'h0, 16'h7fff, 16'h8000,
			32'h0, 32'h0));
		send_word(mk(32'h1234_5678, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 16'h8000,
			16'h7fff, '1, '1));

		// Inverted source through the two low logic terms, 8 bpp
		set_regs(cmd_bit(CmdLfu0) | cmd_bit(CmdLfu1), 15'h0, 15'h0, 8'h00, Depth8, 1'b0);
		send_word(mk(32'h0000_00a5, 32'h0000_005a, 32'h1, 32'h2, 16'h0, 16'h0, 32'h0, 32'h0));

		// Additive with saturation on both low components
		set_regs(cmd_bit(CmdAdd), 15'h0, 15'h0, 8'h00, Depth16, 1'b0);
		send_word(mk(32'h0000_ffff, 32'h0000_ffff, 32'h0, 32'h0, 16'h1, 16'h1, 32'h0, 32'h0));
		send_word(mk(32'h0000_0780, 32'h0000_0990, 32'h0, 32'h0, 16'h1, 16'h1, 32'h0, 32'h0));

		// Additive without saturation: carries fold into the next component
		set_regs(cmd_bit(CmdAdd) | cmd_bit(CmdNoSatLo) | cmd_bit(CmdNoSatMid),
			15'h0, 15'h0, 8'h00, Depth32, 1'b0);
		send_word(mk(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 16'h2, 16'h2, 32'h0, 32'h0));
		send_word(mk(32'h0000_0780, 32'h0000_0990, 32'h0, 32'h0, 16'h2, 16'h2, 32'h0, 32'h0));

		// Pattern write at 4 bpp
		set_regs(cmd_bit(CmdPattern) | cmd_bit(CmdZWrite), 15'h0, 15'h0, 8'h00, Depth4,
			1'b0);
		send_word(mk(32'h1, 32'h2, 32'h3, 32'h4, 16'h0, 16'h0, 32'h5, 32'h89ab_cdef));

		// Clip rectangle 10x10 plus inhibit on equal Z: inside, right, left and bottom edges, then equal Z
		set_regs(cmd_bit(CmdClip) | cmd_bit(CmdZEq) | cmd_bit(CmdZWrite) | cmd_bit(CmdLfu3),
			15'd10, 15'd10, 8'h00, Depth32, 1'b0);
		send_word(mk(32'hcafe_0001, 32'hffff_ffff, 32'h1, 32'h2, 16'd9, 16'd9, 32'h0, 32'h0));
		send_word(mk(32'hcafe_0002, 32'h0f0f_0f0f, 32'h1, 32'h2, 16'd10, 16'd0, 32'h0, 32'h0));
		send_word(mk(32'hcafe_0003, 32'h0f0f_0f0f, 32'h1, 32'h2, 16'hffff, 16'd0, 32'h0,
			32'h0));
		send_word(mk(32'hcafe_0004, 32'h0f0f_0f0f, 32'h1, 32'h2, 16'd0, 16'd10, 32'h0, 32'h0));
		send_word(mk(32'hcafe_0005, 32'h0f0f_0f0f, 32'h7, 32'h7, 16'd0, 16'd0, 32'h0, 32'h0));

		// Data compare against the source lane, then against the destination lane
		set_regs(cmd_bit(CmdDcmp) | cmd_bit(CmdLfu3), 15'h0, 15'h0, 8'h00, Depth32, 1'b0);
		send_word(mk(32'h5555_aaaa, 32'hffff_ffff, 32'h0, 32'h1, 16'h0, 16'h0, 32'h5555_aaaa,
			32'h0));
		set_regs(cmd_bit(CmdDcmp) | cmd_bit(CmdDcmpDst) | cmd_bit(CmdLfu3), 15'h0, 15'h0,
			8'h00, Depth32, 1'b0);
		send_word(mk(32'hffff_ffff, 32'h3333_cccc, 32'h0, 32'h1, 16'h0, 16'h0, 32'h0,
			32'h3333_cccc));

		// Inhibit on less and greater Z; equal Z passes
		set_regs(cmd_bit(CmdZLt) | cmd_bit(CmdZGt) | cmd_bit(CmdLfu3), 15'h0, 15'h0, 8'h00,
			Depth32, 1'b0);
		send_word(mk('1, 32'h1111_1111, 32'h0, 32'hffff_ffff, 16'h0, 16'h0, 32'h0, 32'h0));
		send_word(mk('1, 32'h2222_2222, 32'hffff_ffff, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0));
		send_word(mk('1, 32'h3333_3333, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'h0, 32'h0,
			32'h0));

		// Clipped pixel still written in phrase mode, and by force write
		set_regs(cmd_bit(CmdClip) | cmd_bit(CmdLfu3), 15'h0, 15'h0, 8'h00, Depth32, 1'b1);
		send_word(mk('1, 32'h4444_4444, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0));
		set_regs(cmd_bit(CmdClip) | cmd_bit(CmdForce) | cmd_bit(CmdZWrite), 15'h0, 15'h0,
			8'h00, Depth16, 1'b0);
		send_word(mk('1, 32'h5555_6666, 32'h9, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0));

		// Shading clamps at both ends of the intensity range
		set_regs(cmd_bit(CmdShade), 15'h0, 15'h0, 8'h80, Depth32, 1'b0);
		send_word(mk(32'h1234_5605, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0));
		set_regs(cmd_bit(CmdShade) | cmd_bit(CmdAdd), 15'h0, 15'h0, 8'h7f, Depth32, 1'b0);
		send_word(mk(32'h0000_abfe, 32'h0000_0101, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 32'h0));

		// Undefined pixel size codes suppress every write, even in phrase mode
		set_regs(cmd_bit(CmdLfu3) | cmd_bit(CmdZWrite), 15'h0, 15'h0, 8'h00, DepthBad6, 1'b0);
		send_word(mk('1, '1, 32'h1, 32'h1, 16'h0, 16'h0, 32'h0, 32'h0));
		set_regs(cmd_bit(CmdLfu3) | cmd_bit(CmdForce), 15'h0, 15'h0, 8'h00, DepthBad7, 1'b1);
		send_word(mk('1, '1, 32'h1, 32'h1, 16'h0, 16'h0, 32'h0, 32'h0));

		// Random phases: registers at their top (shade delta most negative), then at the bottom
		// (shade delta most positive), then random settings, each with its own sender gap pattern.
		sent  = 0;
		phase = 0;
		while (sent < RandomItems) begin
			if (phase == 0) begin
				set_regs('1, 15'h7fff, 15'h7fff, 8'h80, Depth32, 1'b1);
			end else if (phase == 1) begin
				set_regs('0, 15'h0, 15'h0, 8'h7f, Depth1, 1'b0);
			end else begin
				code = $urandom_range(0, 9) >= 8 ? Depth32 : 3'($urandom_range(0, 7));
				set_regs(random_command(), random_clip(), random_clip(), 8'($urandom()),
					code, ($urandom_range(0, 3) == 0));
			end
			gappy      = ($urandom_range(0, 3) != 0);
			words      = $urandom_range(40, 120);
			if (words > RandomItems - sent)
				words = RandomItems - sent;
			burst_left = $urandom_range(1, 16);
			repeat (words) begin
				send_word(random_pixel());
				sent++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					if (gappy) begin
						in_valid <= 1'b0;
						repeat ($urandom_range(1, 12))
							@(posedge clk);
					end
				end
			end
			phase++;
		end

		// Drain the pipe and let the tail settle before the verdict
		wait_idle();
		repeat (DrainCycles)
			@(posedge clk);
		if (mismatches == 0 && pending_writes == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/brop_pkg.sv
design/brop_cfg_regs.sv
design/brop_stage1.sv
design/brop_stage2.sv
design/brop_stage3.sv
design/blitter_pixel_raster_op.sv
test/raster_op_checker.sv
test/tb_top.sv
